[sv/qmi_pkg.sv]
// ----------------------------------------------------------------------------
// qmi_pkg
// Shared types and codes for the queue with middle insertion.
// ----------------------------------------------------------------------------
package qmi_pkg;

   localparam int CAPACITY_DEFAULT = 64;
   localparam int DATA_W           = 32;

   typedef logic signed [DATA_W-1:0] entry_type;

   // request kinds
   localparam logic [1:0] REQ_PUSH   = 2'd0;
   localparam logic [1:0] REQ_INSERT = 2'd1;
   localparam logic [1:0] REQ_POP    = 2'd2;
   // bit of the request kind that selects a pop
   localparam int         REQ_POP_BIT = 1;

   // result status codes
   localparam logic [1:0] ST_STORED     = 2'd0;
   localparam logic [1:0] ST_POPPED     = 2'd1;
   localparam logic [1:0] ST_POP_EMPTY  = 2'd2;
   localparam logic [1:0] ST_QUEUE_FULL = 2'd3;

   // control broadcast to every cell of the chain
   typedef struct packed {
      logic      pop;     // every cell takes its upper neighbor
      logic      store;   // open a slot at the insert position
      entry_type value;   // value written into the opened slot
   } cell_ctrl_type;

endpackage

[sv/qmi_cell.sv]
// ----------------------------------------------------------------------------
// qmi_cell
// One queue slot; shifts toward the head on pop, away from it on insert.
// ----------------------------------------------------------------------------
module qmi_cell #(
   parameter int IDX   = 0,
   parameter int CNT_W = 7
) (
   input  logic                  clock,
   input  qmi_pkg::cell_ctrl_type ctrl,
   input  logic [CNT_W-1:0]      pos,
   input  qmi_pkg::entry_type    prev_data,
   input  qmi_pkg::entry_type    next_data,
   output qmi_pkg::entry_type    data
);
   import qmi_pkg::*;

   localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

   entry_type data_ff;
   entry_type data_in;

   // next slot content
   always_comb begin
      data_in = data_ff;
      if (ctrl.pop) begin
         data_in = next_data;
      end else if (ctrl.store) begin
         if (MY_IDX == pos) begin
            data_in = ctrl.value;
         end else if (MY_IDX > pos) begin
            data_in = prev_data;
         end
      end
   end

   // slot storage, no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

[sv/queue_with_middle_insert_core.sv]
// ----------------------------------------------------------------------------
// queue_with_middle_insert_core
// Response: registered; valid in the cycle after request acceptance.
// Throughput: one request per cycle while rsp_ready is high; the whole
// chain of slot cells shifts in parallel.
// Reset: clears the entry count and the response valid; slot contents
// are left undefined and are never read before being written.
// ----------------------------------------------------------------------------
module queue_with_middle_insert_core #(
   parameter int CAPACITY = qmi_pkg::CAPACITY_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_type,
   input  qmi_pkg::entry_type req_item_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output qmi_pkg::entry_type rsp_popped_value
);
   import qmi_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       status_ff, status_in;
   entry_type        popped_ff, popped_in;

   logic             accept;
   logic             is_pop;
   logic [CNT_W:0]   count_plus;
   logic [CNT_W-1:0] pos;
   cell_ctrl_type    ctrl;
   entry_type        chain [CAPACITY];

   // input handshake: output register frees up or is being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_pop    = req_type[REQ_POP_BIT];

   // insert position: middle for insert, tail for push
   assign count_plus = {1'b0, count_ff} + {{CNT_W{1'b0}}, 1'b1};
   assign pos = (req_type == REQ_INSERT) ? count_plus[CNT_W:1] : count_ff;

   // request decode and response build
   always_comb begin
      ctrl.pop   = 1'b0;
      ctrl.store = 1'b0;
      ctrl.value = req_item_value;
      count_in   = count_ff;
      status_in  = status_ff;
      popped_in  = popped_ff;
      if (accept) begin
         popped_in = '0;
         if (is_pop) begin
            if (count_ff == '0) begin
               status_in = ST_POP_EMPTY;
            end else begin
               ctrl.pop  = 1'b1;
               status_in = ST_POPPED;
               popped_in = chain[0];
               count_in  = count_ff - CNT_W'(1);
            end
         end else if (count_ff >= CAP) begin
            status_in = ST_QUEUE_FULL;
         end else begin
            ctrl.store = 1'b1;
            status_in  = ST_STORED;
            count_in   = count_ff + CNT_W'(1);
         end
      end
   end

   // response valid tracking
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload registers
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      popped_ff <= popped_in;
   end

   // chain of slot cells, head at index zero
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type prev_d, next_d;
      if (i == 0) begin : g_head
         assign prev_d = '0;
      end else begin : g_mid
         assign prev_d = chain[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign next_d = '0;
      end else begin : g_body
         assign next_d = chain[i+1];
      end
      qmi_cell #(
         .IDX   (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .pos       (pos),
         .prev_data (prev_d),
         .next_data (next_d),
         .data      (chain[i])
      );
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_popped_value = popped_ff;

endmodule

[sv/qmi_checker.sv]
// ----------------------------------------------------------------------------
// qmi_checker
// Port-level checks for the queue with middle insertion.
// ----------------------------------------------------------------------------
module qmi_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [1:0]         req_type,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_status,
   input qmi_pkg::entry_type rsp_popped_value
);
   import qmi_pkg::*;

   // stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_popped_value))
      else $error("response changed while stalled");

   // every accepted transaction yields a response next cycle
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted transaction without response");

   // popped value is zero unless a pop succeeded
   a_pop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_POPPED |-> rsp_popped_value == '0)
      else $error("nonzero popped value on non-pop status");

   // a store request never reports a pop status
   a_kind_status: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_type[REQ_POP_BIT]
         |=> rsp_status == ST_STORED || rsp_status == ST_QUEUE_FULL)
      else $error("store transaction got pop status");

   // input side is open whenever no response is pending
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

endmodule

bind queue_with_middle_insert_core qmi_checker u_qmi_checker (.*);

[tb/sv/queue_with_middle_insert_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// queue_with_middle_insert_core_test
// Self-checking bench for the middle-insert queue. A shadow queue predicts
// the status and popped value of every request transaction; a monitor
// compares each response transaction against the oldest prediction.
// Directed corner cases, fill/overflow/drain runs, biased random walks,
// a long response hold-off, a full drain pause and a back-to-back finish.
// ----------------------------------------------------------------------------
module queue_with_middle_insert_core_test;

   import qmi_pkg::*;

   localparam int QUEUE_DEPTH = CAPACITY_DEFAULT;

   // request kind 3 decodes as a pop, since only bit 1 selects a pop
   localparam logic [1:0] REQ_POP_ALIAS = 2'd3;

   localparam entry_type VALUE_MIN = 32'sh8000_0000;
   localparam entry_type VALUE_MAX = 32'sh7fff_ffff;

   typedef struct packed {
      logic [1:0] status;
      entry_type  popped;
   } queue_result_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_type;
   entry_type  req_item_value;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [1:0] rsp_status;
   entry_type  rsp_popped_value;

   // shadow copy of the queue contents, head at index 0
   entry_type        shadow_entries[$];
   // predicted responses, oldest first
   queue_result_type pending_results[$];

   int error_count    = 0;
   bit req_idle_on    = 1'b1;
   bit rsp_idle_on    = 1'b1;
   int holdoff_cycles = 0;

   queue_with_middle_insert_core #(
      .CAPACITY(QUEUE_DEPTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_item_value   (req_item_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_popped_value (rsp_popped_value)
   );

   // clock generation
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // shadow queue update and result prediction for one request
   function automatic queue_result_type predict_result(input logic [1:0] kind,
                                                       input entry_type value);
      queue_result_type res;
      int               slot;
      res.status = ST_STORED;
      res.popped = '0;
      if (kind[REQ_POP_BIT]) begin
         if (shadow_entries.size() == 0) begin
            res.status = ST_POP_EMPTY;
         end else begin
            res.popped = shadow_entries.pop_front();
            res.status = ST_POPPED;
         end
      end else if (shadow_entries.size() >= QUEUE_DEPTH) begin
         res.status = ST_QUEUE_FULL;
      end else if (kind == REQ_INSERT) begin
         slot = (shadow_entries.size() + 1) / 2;
         shadow_entries.insert(slot, value);
      end else begin
         shadow_entries.push_back(value);
      end
      return res;
   endfunction

   // offer one request transaction and hold it until accepted
   task automatic send_request(input logic [1:0] kind, input entry_type value);
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_item_value <= value;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(predict_result(kind, value));
      // random gap on the request side
      if (req_idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   // stop offering and wait until every predicted response has arrived
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // value mix: field extremes now and then, otherwise any 32-bit pattern
   function automatic entry_type pick_value();
      case ($urandom_range(0, 15))
         0: return VALUE_MIN;
         1: return VALUE_MAX;
         2: return '0;
         3: return -1;
         default: return entry_type'($urandom);
      endcase
   endfunction

   // store with probability grow_pct, otherwise pop
   function automatic logic [1:0] pick_kind(input int grow_pct);
      if ($urandom_range(0, 99) < grow_pct)
         return $urandom_range(0, 1) ? REQ_INSERT : REQ_PUSH;
      return ($urandom_range(0, 3) == 0) ? REQ_POP_ALIAS : REQ_POP;
   endfunction

   task automatic send_random(input int count, input int grow_pct);
      repeat (count) send_request(pick_kind(grow_pct), pick_value());
   endtask

   // response side: random stalls plus an optional long hold-off
   initial begin
      forever begin
         @(posedge clock);
         if (holdoff_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (holdoff_cycles) @(posedge clock);
            holdoff_cycles = 0;
            rsp_ready <= 1'b1;
         end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // response monitor and compare
   always @(posedge clock) begin
      queue_result_type exp_res;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response status=%0d popped=%0d", $time,
                     rsp_status, rsp_popped_value);
            error_count++;
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_status !== exp_res.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        exp_res.status, rsp_status);
               error_count++;
            end
            if (rsp_popped_value !== exp_res.popped) begin
               $display("%0t: popped value expected %0d actual %0d", $time,
                        exp_res.popped, rsp_popped_value);
               error_count++;
            end
         end
      end
   end

   // corner cases: empty pops, both pop codes, extremes, middle positions
   task automatic test_directed();
      send_request(REQ_POP, VALUE_MAX);
      send_request(REQ_POP_ALIAS, VALUE_MIN);
      send_request(REQ_INSERT, VALUE_MAX);
      send_request(REQ_PUSH, VALUE_MIN);
      send_request(REQ_INSERT, 32'sd1);
      send_request(REQ_INSERT, -32'sd1);
      send_request(REQ_PUSH, '0);
      send_request(REQ_INSERT, 32'sh5555_5555);
      send_request(REQ_INSERT, 32'shaaaa_aaaa);
      send_request(REQ_POP, '0);
      send_request(REQ_POP_ALIAS, -32'sd1);
      send_request(REQ_INSERT, 32'sd7);
      send_request(REQ_PUSH, VALUE_MAX);
      repeat (9) send_request(REQ_POP, pick_value());
      send_request(REQ_POP_ALIAS, pick_value());
      send_request(REQ_INSERT, VALUE_MIN);
      send_request(REQ_POP_ALIAS, '0);
   endtask

   // grow to capacity, store into the full queue, then drain past empty
   task automatic test_fill_and_overflow();
      repeat (QUEUE_DEPTH) send_request(pick_kind(100), pick_value());
      send_request(REQ_PUSH, pick_value());
      send_request(REQ_INSERT, pick_value());
      send_request(REQ_PUSH, VALUE_MAX);
      send_request(REQ_INSERT, VALUE_MIN);
      send_random(QUEUE_DEPTH + 2, 0);
   endtask

   // biased random walk, swinging between growing and shrinking phases
   task automatic test_random_walk();
      int grow_bias[8] = '{85, 15, 50, 95, 5, 60, 40, 50};
      foreach (grow_bias[i]) send_random(50, grow_bias[i]);
   endtask

   // long response stall while requests keep coming
   task automatic test_response_holdoff();
      bit saved_idle;
      saved_idle     = req_idle_on;
      req_idle_on    = 1'b0;
      holdoff_cycles = 250;
      send_random(80, 70);
      req_idle_on    = saved_idle;
   endtask

   // request side pauses until every response is back
   task automatic test_pause_and_resume();
      send_random(30, 60);
      wait_for_drain();
      send_random(30, 40);
   endtask

   // final stretch with no gaps on either side
   task automatic test_back_to_back();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      send_random(100, 55);
   endtask

   // main sequence
   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_type       = REQ_PUSH;
      req_item_value = '0;
      rsp_ready      = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_fill_and_overflow();
      test_random_walk();
      test_response_holdoff();
      test_pause_and_resume();
      test_back_to_back();

      wait_for_drain();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
